>>> rtl/b64enc_pkg.sv
// Shared types, constants and the character table of the Base64 stream encoder ('!' for 62, not '+').
// Used by every module of the encoder; depends on nothing else.
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [15:0] GROUP_LIMIT_RESET = 16'hFFFF;

  // Number of bytes pending in the current group.
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  // Bytes that take part in a group.
  localparam logic [1:0] NBYTES_ONE   = 2'd1;
  localparam logic [1:0] NBYTES_TWO   = 2'd2;
  localparam logic [1:0] NBYTES_THREE = 2'd3;

  // Character slot within one job: four group characters, then the terminator.
  localparam logic [2:0] SLOT_FIRST = 3'd0;
  localparam logic [2:0] SLOT_C1    = 3'd1;
  localparam logic [2:0] SLOT_C2    = 3'd2;
  localparam logic [2:0] SLOT_C3    = 3'd3;
  localparam logic [2:0] SLOT_TERM  = 3'd4;

  localparam logic [7:0] CHAR_62   = 8'h21;  // '!'
  localparam logic [7:0] CHAR_63   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_PAD  = 8'h3D;  // '='
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_UA   = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LA   = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       emit;      // four characters go out
    logic       term;      // terminator follows
    logic       complete;  // flag carried by the terminator
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v <= 6'd25) begin
      r = CHAR_UA + {2'b00, v};
    end else if (v <= 6'd51) begin
      r = CHAR_LA + {2'b00, v - 6'd26};
    end else if (v <= 6'd61) begin
      r = CHAR_ZERO + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CHAR_62;
    end else begin
      r = CHAR_63;
    end
    return r;
  endfunction

endpackage

>>> rtl/b64enc_front.sv
// Front end: takes source bytes, collects groups, applies the group limit.
// Produces one job per byte that causes output. Depends on b64enc_pkg.
module b64enc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               push,
  output b64enc_pkg::job_t   push_job
);

  logic [15:0] group_limit;
  logic [7:0]  held_first;
  logic [7:0]  held_second;
  logic [1:0]  phase;
  logic [15:0] groups_emitted;
  logic        dropped;

  logic has_group;
  logic over_limit;
  logic emit_now;

  always_comb begin
    has_group  = (phase == b64enc_pkg::PHASE_TWO) || last_byte;
    over_limit = groups_emitted >= group_limit;
    emit_now   = has_group && !over_limit;

    push_job = '0;
    unique case (phase)
      b64enc_pkg::PHASE_NONE: begin
        push_job.b0     = data_byte;
        push_job.nbytes = b64enc_pkg::NBYTES_ONE;
      end
      b64enc_pkg::PHASE_ONE: begin
        push_job.b0     = held_first;
        push_job.b1     = data_byte;
        push_job.nbytes = b64enc_pkg::NBYTES_TWO;
      end
      default: begin
        push_job.b0     = held_first;
        push_job.b1     = held_second;
        push_job.b2     = data_byte;
        push_job.nbytes = b64enc_pkg::NBYTES_THREE;
      end
    endcase
    push_job.emit     = emit_now;
    push_job.term     = last_byte;
    push_job.complete = !(dropped || (has_group && over_limit));
    push = accept && (emit_now || last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_limit    <= b64enc_pkg::GROUP_LIMIT_RESET;
      held_first     <= '0;
      held_second    <= '0;
      phase          <= b64enc_pkg::PHASE_NONE;
      groups_emitted <= '0;
      dropped        <= 1'b0;
    end else begin
      if (cfg_we) begin
        group_limit <= cfg_wdata;
      end
      if (accept) begin
        if (last_byte) begin
          held_first     <= '0;
          held_second    <= '0;
          phase          <= b64enc_pkg::PHASE_NONE;
          groups_emitted <= '0;
          dropped        <= 1'b0;
        end else begin
          unique case (phase)
            b64enc_pkg::PHASE_NONE: begin
              held_first <= data_byte;
              phase      <= b64enc_pkg::PHASE_ONE;
            end
            b64enc_pkg::PHASE_ONE: begin
              held_second <= data_byte;
              phase       <= b64enc_pkg::PHASE_TWO;
            end
            default: begin
              held_first  <= '0;
              held_second <= '0;
              phase       <= b64enc_pkg::PHASE_NONE;
              if (emit_now) begin
                groups_emitted <= groups_emitted + 16'd1;
              end else begin
                dropped <= 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

endmodule

>>> rtl/b64enc_queue.sv
// Short job queue between the front end and the character serializer.
// Depends on b64enc_pkg for the job type and depth.
module b64enc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64enc_pkg::job_t push_job,
  input  logic             pop,
  output b64enc_pkg::job_t pop_job,
  output logic             full,
  output logic             nonempty
);

  b64enc_pkg::job_t                        entries [b64enc_pkg::QueueDepth];
  logic [b64enc_pkg::QueuePtrW-1:0]        wr_ptr;
  logic [b64enc_pkg::QueuePtrW-1:0]        rd_ptr;
  logic [b64enc_pkg::QueueCntW-1:0]        count;

  localparam logic [b64enc_pkg::QueueCntW-1:0] CntFull =
    b64enc_pkg::QueueCntW'(b64enc_pkg::QueueDepth);
  localparam logic [b64enc_pkg::QueuePtrW-1:0] PtrLast =
    b64enc_pkg::QueuePtrW'(b64enc_pkg::QueueDepth - 1);

  assign full     = count == CntFull;
  assign nonempty = count != '0;
  assign pop_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/b64enc_back.sv
// Back end: holds one job and sends its characters, one beat per cycle while out_ready is high.
// Depends on b64enc_pkg for the job type and the character table.
module b64enc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  b64enc_pkg::job_t q_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             run_end,
  output logic             complete
);

  b64enc_pkg::job_t job;
  logic             job_valid;
  logic [2:0]       slot;
  logic             is_last;
  logic [5:0]       sextet;

  assign is_last = job.term ? (slot == b64enc_pkg::SLOT_TERM)
                            : (slot == b64enc_pkg::SLOT_C3);
  assign pop = q_nonempty && (!job_valid || (out_ready && is_last));

  assign out_valid = job_valid;
  assign run_end   = is_last;
  assign complete  = (slot == b64enc_pkg::SLOT_TERM) && job.complete;

  always_comb begin
    sextet   = '0;
    out_char = b64enc_pkg::CHAR_NUL;
    unique case (slot)
      b64enc_pkg::SLOT_FIRST: begin
        sextet   = job.b0[7:2];
        out_char = b64enc_pkg::sextet_char(sextet);
      end
      b64enc_pkg::SLOT_C1: begin
        sextet   = {job.b0[1:0], job.b1[7:4]};
        out_char = b64enc_pkg::sextet_char(sextet);
      end
      b64enc_pkg::SLOT_C2: begin
        sextet   = {job.b1[3:0], job.b2[7:6]};
        out_char = (job.nbytes == b64enc_pkg::NBYTES_ONE) ? b64enc_pkg::CHAR_PAD
                                                          : b64enc_pkg::sextet_char(sextet);
      end
      b64enc_pkg::SLOT_C3: begin
        sextet   = job.b2[5:0];
        out_char = (job.nbytes != b64enc_pkg::NBYTES_THREE) ? b64enc_pkg::CHAR_PAD
                                                            : b64enc_pkg::sextet_char(sextet);
      end
      default: begin
        out_char = b64enc_pkg::CHAR_NUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      slot      <= b64enc_pkg::SLOT_FIRST;
    end else if (pop) begin
      job_valid <= 1'b1;
      slot      <= q_job.emit ? b64enc_pkg::SLOT_FIRST : b64enc_pkg::SLOT_TERM;
    end else if (job_valid && out_ready) begin
      if (is_last) begin
        job_valid <= 1'b0;
      end else begin
        slot <= slot + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

endmodule

>>> rtl/base64_stream_encoder_top.sv
// Top level of the Base64 stream encoder: front end, job queue, serializer.
// Depends on b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
//
//   Channel  Direction  Handshake           Beat contents
//   input    in         in_valid/in_ready   data_byte, last_byte
//   output   out        out_valid/out_ready out_char, run_end, complete
//   config   in         cfg_we              cfg_wdata (group limit)
//
// A byte is taken whenever the two-entry job queue has room.
// Each job then occupies the serializer for one beat per character: four for
// a group, one for the terminator, five for both, so the output port sets the
// sustained rate.
// Reset clears all stream state and sets the group limit to its maximum.
// A stalled output backs up into the queue, and input stalls only when it is full.
module base64_stream_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        run_end,
  output logic        complete
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_nonempty;
  b64enc_pkg::job_t push_job;
  b64enc_pkg::job_t pop_job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .push_job  (push_job)
  );

  b64enc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_job      (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_end    (run_end),
    .complete   (complete)
  );

endmodule

>>> rtl/b64enc_checker.sv
// Port-level checks for the Base64 stream encoder, bound to its top level.
// Depends on base64_stream_encoder_top's port list only.
module b64enc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic        run_end,
  input logic        complete
);

  // After reset the queue is empty and nothing is pending on the output.
  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("encoder not idle after reset");

  // A byte beat offered to the encoder waits unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
    else $error("input beat changed while stalled");

  // A beat held by the consumer must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_end)
                                && $stable(complete))
    else $error("output beat changed while stalled");

  // The complete flag only rides on the terminator, which closes the run.
  a_complete_on_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && complete |-> out_char == 8'h00 && run_end)
    else $error("complete flag outside a terminator");

  // A terminator always ends the run of its byte.
  a_term_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 8'h00 |-> run_end)
    else $error("terminator without run end");

endmodule

bind base64_stream_encoder_top b64enc_checker u_b64enc_checker (.*);
